// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ===== design/fpcop_pkg.sv =====
package fpcop_pkg;

  localparam int REG_BITS   = 10;
  localparam int FRAC_COP   = 8;
  localparam int FZ_W       = 12;
  localparam int MXY_W      = 24;
  localparam int MZ_W       = 23;
  localparam int COP_W      = 32;
  localparam int RATIO_W    = 26;
  localparam int RTOT_W     = 27;
  localparam int CFG_IDX_W  = 2;

  // With Fx = Fy = Fz every ratio is exactly one, and the total is floor(sqrt(2)) in Q14.
  localparam logic [RATIO_W-1:0] RATIO_ONE   = 26'd16384;
  localparam logic [RTOT_W-1:0]  RATIO_TOTAL = 27'd23170;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_SPAN_X      = 2'd0,
    REG_HALF_SPAN_Y      = 2'd1,
    REG_SURFACE_OFFSET_Z = 2'd2,
    REG_NONE             = 2'd3
  } reg_index_t;

  // Fields that ride along the divider pipeline, already at output widths.
  typedef struct packed {
    logic                     zero;
    logic [FZ_W-1:0]          fz;
    logic signed [MXY_W-1:0]  mx1;
    logic signed [MXY_W-1:0]  my1;
    logic signed [MZ_W-1:0]   mz;
    logic                     neg_x;
    logic                     neg_y;
  } side_t;

endpackage

// ===== design/fpcop_channels.sv =====
interface fpcop_in_if #(parameter int SAMPLE_BITS = 10);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_rear_right;
  logic [SAMPLE_BITS-1:0] sample_rear_left;
  logic [SAMPLE_BITS-1:0] sample_front_left;
  logic [SAMPLE_BITS-1:0] sample_front_right;

  modport source(output valid, sample_rear_right, sample_rear_left, sample_front_left,
                 sample_front_right, input ready);
  modport sink(input valid, sample_rear_right, sample_rear_left, sample_front_left,
               sample_front_right, output ready);
endinterface

interface fpcop_out_if;
  import fpcop_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FZ_W-1:0]          force_vertical;
  logic signed [MXY_W-1:0]  moment_about_x;
  logic signed [MXY_W-1:0]  moment_about_y;
  logic signed [MZ_W-1:0]   moment_about_z;
  logic signed [COP_W-1:0]  pressure_center_x;
  logic signed [COP_W-1:0]  pressure_center_y;
  logic [RATIO_W-1:0]       friction_ratio_x;
  logic [RATIO_W-1:0]       friction_ratio_y;
  logic [RTOT_W-1:0]        friction_ratio_total;
  logic                     zero_load;

  modport source(output valid, force_vertical, moment_about_x, moment_about_y,
                 moment_about_z, pressure_center_x, pressure_center_y, friction_ratio_x,
                 friction_ratio_y, friction_ratio_total, zero_load, input ready);
  modport sink(input valid, force_vertical, moment_about_x, moment_about_y,
               moment_about_z, pressure_center_x, pressure_center_y, friction_ratio_x,
               friction_ratio_y, friction_ratio_total, zero_load, output ready);
endinterface

// ===== design/fpcop_front.sv =====
module fpcop_front import fpcop_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [SAMPLE_BITS-1:0]    s1,
  input  logic [SAMPLE_BITS-1:0]    s2,
  input  logic [SAMPLE_BITS-1:0]    s3,
  input  logic [SAMPLE_BITS-1:0]    s4,
  input  logic [REG_BITS-1:0]       dx,
  input  logic [REG_BITS-1:0]       dy,
  input  logic [REG_BITS-1:0]       dz,
  output logic                      out_valid,
  output side_t                     side,
  output logic [SAMPLE_BITS+21:0]   num_x,
  output logic [SAMPLE_BITS+21:0]   num_y,
  output logic [SAMPLE_BITS+1:0]    den
);
  localparam int FW = SAMPLE_BITS + 2;   // Fz
  localparam int DW = SAMPLE_BITS + 3;   // signed pair differences
  localparam int MW = SAMPLE_BITS + 14;  // Mx1, My1
  localparam int ZW = SAMPLE_BITS + 13;  // Mz
  localparam int NW = MW + FRAC_COP;

  logic [3:0] vld;

  // stage 1: sums and differences
  logic [FW-1:0]        fz1;
  logic signed [DW-1:0] a1, b1;
  // stage 2: products
  logic [FW-1:0]        fz2;
  logic signed [MW-1:0] pmx2, pmy2;
  logic [MW-2:0]        pz2;
  // stage 3: surface moments
  logic [FW-1:0]        fz3;
  logic signed [MW-1:0] mx3, my3;
  logic signed [ZW-1:0] mz3;

  logic signed [DW-1:0] e1, e2, e3, e4;
  assign e1 = $signed({3'b000, s1});
  assign e2 = $signed({3'b000, s2});
  assign e3 = $signed({3'b000, s3});
  assign e4 = $signed({3'b000, s4});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fz1  <= FW'(s1) + FW'(s2) + FW'(s3) + FW'(s4);
      a1   <= e1 + e2 - e3 - e4;
      b1   <= e2 + e3 - e1 - e4;

      fz2  <= fz1;
      pmx2 <= MW'($signed({1'b0, dy}) * a1);
      pmy2 <= MW'($signed({1'b0, dx}) * b1);
      pz2  <= (MW-1)'(fz1 * dz);

      fz3  <= fz2;
      mx3  <= pmx2 + $signed({1'b0, pz2});
      my3  <= pmy2 - $signed({1'b0, pz2});
      mz3  <= ZW'(-(pmx2 + pmy2));

      side.zero  <= (fz3 == '0);
      side.fz    <= FZ_W'(fz3);
      side.mx1   <= MXY_W'(mx3);
      side.my1   <= MXY_W'(my3);
      side.mz    <= MZ_W'(mz3);
      side.neg_x <= (my3 > 0);
      side.neg_y <= mx3[MW-1];
      num_x      <= {(my3[MW-1] ? MW'(-my3) : MW'(my3)), {FRAC_COP{1'b0}}};
      num_y      <= {(mx3[MW-1] ? MW'(-mx3) : MW'(mx3)), {FRAC_COP{1'b0}}};
      den        <= fz3;
    end
  end

  assign out_valid = vld[3];

  logic [NW-1:0] unused_check;
  assign unused_check = num_x ^ num_y;
endmodule

// ===== design/fpcop_div.sv =====
module fpcop_div import fpcop_pkg::*; #(
  parameter int NW  = 32,
  parameter int DW  = 12,
  parameter int BPS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num_x,
  input  logic [NW-1:0] num_y,
  input  logic [DW-1:0] den,
  input  side_t         side_in,
  output logic          out_valid,
  output logic [NW-1:0] quo_x,
  output logic [NW-1:0] quo_y,
  output side_t         side_out
);
  localparam int DEPTH = (NW + BPS - 1) / BPS;

  // restoring division, BPS quotient bits per stage; {rem, num/quotient}
  function automatic logic [DW+NW-1:0] div_steps(input logic [DW+NW-1:0] rn,
                                                  input logic [DW-1:0] d, input int first);
    logic [DW:0]   t;
    logic [DW-1:0] r;
    logic [NW-1:0] n;
    r = rn[DW+NW-1:NW];
    n = rn[NW-1:0];
    for (int j = 0; j < BPS; j++) begin
      if (first + j < NW) begin
        t = {r, n[NW-1]};
        n = n << 1;
        if (t >= {1'b0, d}) begin
          r    = DW'(t - {1'b0, d});
          n[0] = 1'b1;
        end else begin
          r = t[DW-1:0];
        end
      end
    end
    return {r, n};
  endfunction

  logic [DEPTH-1:0]       vld;
  logic [DW+NW-1:0]       rnx  [DEPTH];
  logic [DW+NW-1:0]       rny  [DEPTH];
  logic [DW-1:0]          dreg [DEPTH];
  side_t                  sreg [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnx[0]  <= div_steps({{DW{1'b0}}, num_x}, den, 0);
      rny[0]  <= div_steps({{DW{1'b0}}, num_y}, den, 0);
      dreg[0] <= den;
      sreg[0] <= side_in;
    end
  end

  for (genvar s = 1; s < DEPTH; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        rnx[s]  <= div_steps(rnx[s-1], dreg[s-1], s * BPS);
        rny[s]  <= div_steps(rny[s-1], dreg[s-1], s * BPS);
        dreg[s] <= dreg[s-1];
        sreg[s] <= sreg[s-1];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign quo_x     = rnx[DEPTH-1][NW-1:0];
  assign quo_y     = rny[DEPTH-1][NW-1:0];
  assign side_out  = sreg[DEPTH-1];

  logic [DW-1:0] unused_rem;
  assign unused_rem = rnx[DEPTH-1][DW+NW-1:NW] ^ rny[DEPTH-1][DW+NW-1:NW]
                      ^ dreg[DEPTH-1];
endmodule

// ===== design/force_plate_center_of_pressure_core.sv =====
// Four-sensor force plate: takes one beat of four load-cell readings and returns one beat with
// Fz, the surface moments Mx1/My1, Mz, the center of pressure (Q8, truncated toward zero) and
// the friction ratios (Q14). A new beat is taken every cycle while the output is not stalled;
// each passes the front-end stages, the 4-bit-per-stage divider (NW = SAMPLE_BITS + 22 bits)
// for the center of pressure and an output register. The whole pipeline holds while a result
// waits (ready low), so nothing is dropped. Zero load forces the quotient fields to 0 and raises
// zero_load. Registers: 0 half_span_x, 1 half_span_y, 2 surface_offset_z; other indexes ignored.
`include "assert_macros.svh"

module force_plate_center_of_pressure_core import fpcop_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  fpcop_in_if.sink             samples,
  fpcop_out_if.source          results,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_BITS-1:0]  cfg_data
);
  localparam int FW = SAMPLE_BITS + 2;
  localparam int NW = SAMPLE_BITS + 22;

  // configuration registers
  logic [REG_BITS-1:0] half_span_x, half_span_y, surface_offset_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_span_x      <= '0;
      half_span_y      <= '0;
      surface_offset_z <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_HALF_SPAN_X:      half_span_x      <= cfg_data;
        REG_HALF_SPAN_Y:      half_span_y      <= cfg_data;
        REG_SURFACE_OFFSET_Z: surface_offset_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: pipeline moves when the output slot is free or being taken
  logic adv;
  assign adv           = !results.valid || results.ready;
  assign samples.ready = adv;

  logic          f_valid;
  side_t         f_side;
  logic [NW-1:0] f_num_x, f_num_y;
  logic [FW-1:0] f_den;

  fpcop_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (samples.valid),
    .s1        (samples.sample_rear_right),
    .s2        (samples.sample_rear_left),
    .s3        (samples.sample_front_left),
    .s4        (samples.sample_front_right),
    .dx        (half_span_x),
    .dy        (half_span_y),
    .dz        (surface_offset_z),
    .out_valid (f_valid),
    .side      (f_side),
    .num_x     (f_num_x),
    .num_y     (f_num_y),
    .den       (f_den)
  );

  logic          d_valid;
  logic [NW-1:0] q_x, q_y;
  side_t         d_side;

  fpcop_div #(.NW(NW), .DW(FW), .BPS(4)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (f_valid),
    .num_x     (f_num_x),
    .num_y     (f_num_y),
    .den       (f_den),
    .side_in   (f_side),
    .out_valid (d_valid),
    .quo_x     (q_x),
    .quo_y     (q_y),
    .side_out  (d_side)
  );

  // sign restore; divide-by-zero garbage is masked by the zero flag
  logic signed [NW:0] cop_x, cop_y;
  assign cop_x = d_side.neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
  assign cop_y = d_side.neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (adv) begin
      results.valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      results.force_vertical       <= d_side.fz;
      results.moment_about_x       <= d_side.mx1;
      results.moment_about_y       <= d_side.my1;
      results.moment_about_z       <= d_side.mz;
      results.zero_load            <= d_side.zero;
      results.pressure_center_x    <= d_side.zero ? '0 : COP_W'(cop_x);
      results.pressure_center_y    <= d_side.zero ? '0 : COP_W'(cop_y);
      results.friction_ratio_x     <= d_side.zero ? '0 : RATIO_ONE;
      results.friction_ratio_y     <= d_side.zero ? '0 : RATIO_ONE;
      results.friction_ratio_total <= d_side.zero ? '0 : RATIO_TOTAL;
    end
  end

  `ASSERT_IMPL(a_zero_cop, clk, rst, results.valid && results.zero_load, results.pressure_center_x == 0 && results.pressure_center_y == 0, "zero load with nonzero center of pressure")
  `ASSERT_IMPL(a_zero_fz, clk, rst, results.valid, results.zero_load == (results.force_vertical == 0), "zero flag disagrees with Fz")
  `ASSERT_IMPL(a_hold, clk, rst, results.valid && !results.ready, ##1 results.valid, "result dropped during stall")
  `ASSERT_ALWAYS(a_ready, clk, rst, samples.ready == (!results.valid || results.ready), "input ready not tied to output slot")
endmodule
